FILE: src/rtpm_pkg.sv
// Package for the route table prefix match block.
// Holds op codes, status codes, route states and the entry record type.
`timescale 1ns / 1ps
package rtpm_pkg;

    localparam logic [1:0] OP_LEARN      = 2'd0;
    localparam logic [1:0] OP_FIND       = 2'd1;
    localparam logic [1:0] OP_ACTIVATE   = 2'd2;
    localparam logic [1:0] OP_INVALIDATE = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BADARG  = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_NOROUTE = 3'd3;
    localparam logic [2:0] ST_KNOWN   = 3'd4;

    localparam logic [1:0] RS_ACTIVE  = 2'd1;
    localparam logic [1:0] RS_INVALID = 2'd2;

    localparam logic [7:0] MAX_PREFIX = 8'd128;

    // Route entry as stored in the table memory (route state kept apart)
    typedef struct packed {
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [7:0]  prefix;
        logic [7:0]  mtype;
        logic [7:0]  metric;
        logic [15:0] seq;
        logic [63:0] orig_hi;
        logic [63:0] orig_lo;
        logic [63:0] hop_hi;
        logic [63:0] hop_lo;
        logic [15:0] port;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Top-n bit mask over 128 bits, n in 0..128
    function automatic logic [127:0] prefix_mask(input logic [7:0] n);
        logic [127:0] m;
        m = '0;
        for (int b = 0; b < 128; b++)
        begin
            m[127 - b] = (8'(b) < n);
        end
        return m;
    endfunction

endpackage

FILE: src/rtpm_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module rtpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/route_table_prefix_match.sv
// Route table with longest-prefix match: learn, find, activate, invalidate.
// Learn and find scan every entry, one memory read per cycle, and learn then writes a new
// entry when it stores one; activate and invalidate skip the scan. One op at a time, with the
// input ready again in the cycle after the result transfer; the result is held while m_tready
// is low. Reset clears the used and route state bits at once; no clearing pass is needed.
// Depends on rtpm_pkg, rtpm_ram.
`timescale 1ns / 1ps
module route_table_prefix_match
    import rtpm_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op[1:0], addr_hi, addr_lo, prefix_bits, metric_info, seq_number,
    // orig_hi, orig_lo, hop_hi, hop_lo, port_id, entry_sel (pad to 448 bits)
    input  logic [447:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], entry_index[3:0], out_hop_hi, out_hop_lo, out_port,
    // out_metric, out_seq, out_prefix (pad to 184 bits)
    output logic [183:0] m_tdata
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_DONE = 5'b00100,
        S_WRIT = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Captured input fields
    logic [1:0]   op_reg;
    logic [127:0] addr_reg;
    logic [7:0]   plen_reg;
    logic [15:0]  minfo_reg, seq_reg, port_reg;
    logic [127:0] orig_reg, hop_reg;
    logic [3:0]   sel_reg;

    // Scan control
    logic [CW-1:0] rd_cnt_reg;
    logic          chk_reg;
    logic [IW-1:0] chk_idx_reg;
    logic          hit_reg, free_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg;
    entry_t        best_reg;

    logic [ENTRIES-1:0] used_reg;
    logic [1:0]         rstate_reg [ENTRIES];

    logic [2:0]  status_reg;
    logic [3:0]  idx_reg;
    entry_t      res_reg;

    entry_t        rd_entry;
    logic [IW-1:0] raddr;
    logic          we;

    assign raddr = rd_cnt_reg[IW-1:0];

    rtpm_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (free_idx_reg),
        .wdata ({addr_reg, plen_reg, minfo_reg[15:8], minfo_reg[7:0], seq_reg,
                 orig_reg, hop_reg, port_reg}),
        .raddr (raddr),
        .rdata (rd_entry)
    );

    logic [7:0]   plen_in;
    logic [127:0] pmask;
    logic         covers, zero_addr, sel_ok;

    assign plen_in  = (s_tdata[137:130] > MAX_PREFIX) ? MAX_PREFIX : s_tdata[137:130];
    assign pmask    = prefix_mask(rd_entry.prefix);
    assign covers   = (({rd_entry.addr_hi, rd_entry.addr_lo} ^ addr_reg) & pmask) == '0;
    assign zero_addr = (addr_reg == '0);
    assign sel_ok   = (32'(sel_reg) < ENTRIES) && used_reg[sel_reg[IW-1:0]];
    assign we       = (state_reg == S_WRIT);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {1'b0, res_reg.prefix, res_reg.seq, res_reg.metric, res_reg.port,
                       res_reg.hop_lo, res_reg.hop_hi, idx_reg, status_reg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (s_tdata[1] == 1'b1) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (chk_reg && 32'(chk_idx_reg) == ENTRIES - 1)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (op_reg == OP_LEARN && !hit_reg && !(plen_reg == 8'd0 || zero_addr)
                    && free_reg)
                begin
                    state_next = S_WRIT;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_WRIT: state_next = S_OUT;
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rd_cnt_reg <= '0;
            chk_reg    <= 1'b0;
            used_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rstate_reg[i] <= 2'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            chk_reg   <= 1'b0;
            if (state_reg == S_IDLE)
            begin
                rd_cnt_reg <= '0;
            end
            else if (state_reg == S_SCAN && 32'(rd_cnt_reg) < ENTRIES)
            begin
                chk_reg    <= 1'b1;
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end
            if (we)
            begin
                used_reg[free_idx_reg] <= 1'b1;
            end
            if (state_reg == S_DONE && op_reg[1] && sel_ok)
            begin
                rstate_reg[sel_reg[IW-1:0]] <= (op_reg == OP_ACTIVATE) ? RS_ACTIVE : RS_INVALID;
            end
        end
    end

    // Payload: capture, scan compare, result
    always_ff @(posedge clk)
    begin
        chk_idx_reg <= raddr;
        if (state_reg == S_IDLE && s_tvalid)
        begin
            op_reg    <= s_tdata[1:0];
            addr_reg  <= {s_tdata[65:2], s_tdata[129:66]};
            plen_reg  <= plen_in;
            minfo_reg <= s_tdata[153:138];
            seq_reg   <= s_tdata[169:154];
            orig_reg  <= {s_tdata[233:170], s_tdata[297:234]};
            hop_reg   <= {s_tdata[361:298], s_tdata[425:362]};
            port_reg  <= s_tdata[441:426];
            sel_reg   <= s_tdata[445:442];
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            hit_idx_reg  <= '0;
            free_idx_reg <= '0;
        end
        if (chk_reg)
        begin
            if (op_reg == OP_LEARN)
            begin
                if (!hit_reg && used_reg[chk_idx_reg] && covers
                    && rd_entry.prefix == plen_reg && rd_entry.mtype == minfo_reg[15:8]
                    && {rd_entry.orig_hi, rd_entry.orig_lo} == orig_reg)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= chk_idx_reg;
                end
                if (!free_reg && !used_reg[chk_idx_reg])
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= chk_idx_reg;
                end
            end
            else if (used_reg[chk_idx_reg] && rstate_reg[chk_idx_reg] != RS_INVALID
                     && covers && (!hit_reg || best_reg.prefix < rd_entry.prefix))
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= chk_idx_reg;
                best_reg    <= rd_entry;
            end
        end
        if (state_reg == S_DONE)
        begin
            res_reg    <= '0;
            idx_reg    <= '0;
            status_reg <= ST_OK;
            case (op_reg)
                OP_LEARN:
                begin
                    if (hit_reg)
                    begin
                        status_reg <= ST_KNOWN;
                        idx_reg    <= 4'(hit_idx_reg);
                    end
                    else if (plen_reg == 8'd0 || zero_addr)
                    begin
                        status_reg <= ST_BADARG;
                    end
                    else if (!free_reg)
                    begin
                        status_reg <= ST_FULL;
                    end
                    else
                    begin
                        idx_reg <= 4'(free_idx_reg);
                    end
                end
                OP_FIND:
                begin
                    if (zero_addr)
                    begin
                        status_reg <= ST_BADARG;
                    end
                    else if (!hit_reg)
                    begin
                        status_reg <= ST_NOROUTE;
                    end
                    else
                    begin
                        idx_reg <= 4'(hit_idx_reg);
                        res_reg <= best_reg;
                    end
                end
                default:
                begin
                    if (sel_ok)
                    begin
                        idx_reg <= sel_reg;
                    end
                    else
                    begin
                        status_reg <= ST_BADARG;
                    end
                end
            endcase
        end
    end

endmodule

FILE: tb/route_table_prefix_match_test.sv
// Self-checking testbench for route_table_prefix_match: directed table, then random ops.
// Holds its own route table predictor. Depends on rtpm_pkg and the block's RTL.
`timescale 1ns / 1ps
module route_table_prefix_match_test;
    import rtpm_pkg::*;

    localparam int N_ENTRIES = 16;
    localparam int N_RANDOM  = 1335;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 40;

    // Input fields, first field in the lowest bits
    typedef struct packed {
        logic [3:0]  entry_sel;
        logic [15:0] port_id;
        logic [63:0] hop_lo;
        logic [63:0] hop_hi;
        logic [63:0] orig_lo;
        logic [63:0] orig_hi;
        logic [15:0] seq_number;
        logic [15:0] metric_info;
        logic [7:0]  prefix_bits;
        logic [63:0] addr_lo;
        logic [63:0] addr_hi;
        logic [1:0]  op;
    } route_req_t;

    // Result fields, first field in the lowest bits
    typedef struct packed {
        logic [7:0]  out_prefix;
        logic [15:0] out_seq;
        logic [7:0]  out_metric;
        logic [15:0] out_port;
        logic [63:0] out_hop_lo;
        logic [63:0] out_hop_hi;
        logic [3:0]  entry_index;
        logic [2:0]  status;
    } route_rsp_t;

    typedef struct {
        route_req_t req;
        bit         typed;
        route_rsp_t rsp;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [447:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [183:0] m_tdata;

    route_table_prefix_match #(.ENTRIES(N_ENTRIES)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Predicted route table
    bit          rt_used   [N_ENTRIES];
    logic [127:0] rt_addr  [N_ENTRIES];
    logic [7:0]  rt_prefix [N_ENTRIES];
    logic [7:0]  rt_mtype  [N_ENTRIES];
    logic [7:0]  rt_metric [N_ENTRIES];
    logic [15:0] rt_seq    [N_ENTRIES];
    logic [127:0] rt_orig  [N_ENTRIES];
    logic [127:0] rt_hop   [N_ENTRIES];
    logic [15:0] rt_port   [N_ENTRIES];
    logic [1:0]  rt_state  [N_ENTRIES];

    route_rsp_t  pending_rsp[$];
    stim_row_t   directed_rows[$];
    logic [127:0] base_pool[8];
    logic [127:0] orig_pool[3];

    int  error_count;
    int  cycle_count;
    int  rsp_count;
    int  find_hits;
    int  send_idle_pct;
    int  recv_stall_pct;

    // true when the first plen bits of a and b agree
    function automatic bit prefix_agrees(logic [127:0] a, logic [127:0] b, logic [7:0] plen);
        logic [127:0] mask;
        mask = (plen == 0) ? '0 : ~128'd0 << (128 - plen);
        return ((a ^ b) & mask) == '0;
    endfunction

    // Work out the result of one op and update the predicted table
    function automatic route_rsp_t route_predict(route_req_t r);
        route_rsp_t   o;
        logic [127:0] a;
        logic [127:0] orig;
        logic [7:0]   plen;
        logic [7:0]   mtype;
        bit           got;
        int           idx;
        o = '0;
        a = {r.addr_hi, r.addr_lo};
        orig = {r.orig_hi, r.orig_lo};
        plen = (r.prefix_bits > MAX_PREFIX) ? MAX_PREFIX : r.prefix_bits;
        mtype = r.metric_info[15:8];
        got = 0;
        idx = 0;
        o.status = ST_OK;
        if (r.op == OP_LEARN)
        begin
            for (int i = 0; i < N_ENTRIES && !got; i++)
            begin
                if (rt_used[i] && prefix_agrees(rt_addr[i], a, rt_prefix[i])
                    && rt_prefix[i] == plen && rt_mtype[i] == mtype && rt_orig[i] == orig)
                begin
                    got = 1;
                    idx = i;
                end
            end
            if (got)
                o.status = ST_KNOWN;
            else if (plen == 0 || a == '0)
                o.status = ST_BADARG;
            else
            begin
                for (int i = 0; i < N_ENTRIES && !got; i++)
                begin
                    if (!rt_used[i])
                    begin
                        got = 1;
                        idx = i;
                    end
                end
                if (!got)
                    o.status = ST_FULL;
                else
                begin
                    rt_used[idx]   = 1;
                    rt_addr[idx]   = a;
                    rt_prefix[idx] = plen;
                    rt_mtype[idx]  = mtype;
                    rt_metric[idx] = r.metric_info[7:0];
                    rt_seq[idx]    = r.seq_number;
                    rt_orig[idx]   = orig;
                    rt_hop[idx]    = {r.hop_hi, r.hop_lo};
                    rt_port[idx]   = r.port_id;
                end
            end
        end
        else if (r.op == OP_FIND)
        begin
            if (a == '0)
                o.status = ST_BADARG;
            else
            begin
                // longest match, lowest index on ties
                for (int i = 0; i < N_ENTRIES; i++)
                begin
                    if (rt_used[i] && rt_state[i] != RS_INVALID
                        && prefix_agrees(rt_addr[i], a, rt_prefix[i])
                        && (!got || rt_prefix[idx] < rt_prefix[i]))
                    begin
                        got = 1;
                        idx = i;
                    end
                end
                if (!got)
                    o.status = ST_NOROUTE;
                else
                begin
                    {o.out_hop_hi, o.out_hop_lo} = rt_hop[idx];
                    o.out_port   = rt_port[idx];
                    o.out_metric = rt_metric[idx];
                    o.out_seq    = rt_seq[idx];
                    o.out_prefix = rt_prefix[idx];
                end
            end
        end
        else
        begin
            if (!rt_used[r.entry_sel])
                o.status = ST_BADARG;
            else
            begin
                rt_state[r.entry_sel] = (r.op == OP_ACTIVATE) ? RS_ACTIVE : RS_INVALID;
                idx = r.entry_sel;
            end
        end
        if (o.status != ST_OK && o.status != ST_KNOWN)
            idx = 0;
        o.entry_index = idx[3:0];
        return o;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random op: mostly addresses near a small pool of prefixes
    function automatic route_req_t random_req();
        route_req_t   r;
        logic [127:0] a;
        logic [127:0] noise;
        int           pick;
        int           keep;
        r = '0;
        pick = $urandom_range(0, 99);
        r.op = (pick < 30) ? OP_LEARN : (pick < 75) ? OP_FIND
             : (pick < 87) ? OP_ACTIVATE : OP_INVALIDATE;
        a = base_pool[$urandom_range(0, 7)];
        case ($urandom_range(0, 19))
            0:       r.prefix_bits = 8'd0;
            1, 2:    r.prefix_bits = 8'($urandom_range(129, 255));
            3:       r.prefix_bits = 8'd128;
            default: r.prefix_bits = 8'($urandom_range(1, 128));
        endcase
        if (r.op == OP_FIND)
        begin
            // flip bits below a random depth
            keep = $urandom_range(0, 128);
            noise = {rand64(), rand64()};
            if (keep < 128)
                a = a ^ (noise >> keep);
        end
        if ($urandom_range(0, 29) == 0)
            a = {rand64(), rand64()};
        else if ($urandom_range(0, 49) == 0)
            a = '0;
        {r.addr_hi, r.addr_lo} = a;
        r.metric_info = {6'd0, 2'($urandom_range(0, 3)), 8'($urandom)};
        if ($urandom_range(0, 9) == 0)
            r.metric_info = 16'($urandom);
        {r.orig_hi, r.orig_lo} = ($urandom_range(0, 9) == 0) ? {rand64(), rand64()}
                                 : orig_pool[$urandom_range(0, 2)];
        r.seq_number = 16'($urandom);
        r.hop_hi = rand64();
        r.hop_lo = rand64();
        r.port_id = 16'($urandom);
        r.entry_sel = 4'($urandom);
        return r;
    endfunction

    function automatic route_req_t make_req(logic [1:0] op, logic [127:0] a, logic [7:0] plen,
                                            logic [15:0] minfo, logic [127:0] orig,
                                            logic [3:0] sel);
        route_req_t r;
        r = '0;
        r.op = op;
        {r.addr_hi, r.addr_lo} = a;
        r.prefix_bits = plen;
        r.metric_info = minfo;
        {r.orig_hi, r.orig_lo} = orig;
        r.seq_number = 16'($urandom);
        r.hop_hi = rand64();
        r.hop_lo = rand64();
        r.port_id = 16'($urandom);
        r.entry_sel = sel;
        return r;
    endfunction

    task automatic add_row(route_req_t r, bit typed, logic [2:0] st, logic [3:0] idx);
        stim_row_t row;
        row.req = r;
        row.typed = typed;
        row.rsp = '0;
        row.rsp.status = st;
        row.rsp.entry_index = idx;
        directed_rows.push_back(row);
    endtask

    // Hold one transfer on the slave side until it is taken
    task automatic send_req(route_req_t r, bit typed, route_rsp_t typed_rsp);
        route_rsp_t p;
        while ($urandom_range(0, 99) < send_idle_pct)
            @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata = 448'(r);
        do
            @(posedge clk);
        while (!s_tready);
        p = route_predict(r);
        pending_rsp.push_back(typed ? typed_rsp : p);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("route_table_prefix_match_test failed");
            $finish;
        end
    end

    // Drive backpressure on the master side
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        route_rsp_t got;
        route_rsp_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(route_rsp_t)-1:0];
            rsp_count++;
            if (pending_rsp.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: %h", got);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (want.status == ST_OK && got.out_prefix != 0)
                    find_hits++;
                if (got.status != want.status || got.entry_index != want.entry_index
                    || got.out_hop_hi != want.out_hop_hi || got.out_hop_lo != want.out_hop_lo
                    || got.out_port != want.out_port || got.out_metric != want.out_metric
                    || got.out_seq != want.out_seq || got.out_prefix != want.out_prefix)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch at result %0d: expected %h, got %h",
                                 rsp_count, want, got);
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        route_rsp_t blank;
        logic [127:0] ones;
        logic [127:0] top_bit;
        int ph;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        rst_n = 1'b0;
        error_count = 0;
        cycle_count = 0;
        rsp_count = 0;
        find_hits = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        blank = '0;
        ones = ~128'd0;
        top_bit = {1'b1, 127'd0};
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            rt_used[i] = 0;
            rt_addr[i] = '0;
            rt_prefix[i] = '0;
            rt_mtype[i] = '0;
            rt_metric[i] = '0;
            rt_seq[i] = '0;
            rt_orig[i] = '0;
            rt_hop[i] = '0;
            rt_port[i] = '0;
            rt_state[i] = '0;
        end
        for (int i = 0; i < 8; i++)
            base_pool[i] = {rand64(), rand64()} | 128'd1;
        for (int i = 0; i < 3; i++)
            orig_pool[i] = {rand64(), rand64()};

        // Directed rows: empty table, bad arguments, extremes, ties, states
        add_row(make_req(OP_FIND, 128'd1, 8'd0, 16'd0, '0, 4'd0), 1, ST_NOROUTE, 4'd0);
        add_row(make_req(OP_FIND, '0, 8'd0, 16'd0, '0, 4'd0), 1, ST_BADARG, 4'd0);
        add_row(make_req(OP_LEARN, ones, 8'd0, 16'hffff, ones, 4'd0), 1, ST_BADARG, 4'd0);
        add_row(make_req(OP_LEARN, '0, 8'd64, 16'h0101, ones, 4'd0), 1, ST_BADARG, 4'd0);
        add_row(make_req(OP_ACTIVATE, ones, 8'd0, 16'd0, '0, 4'd0), 1, ST_BADARG, 4'd0);
        add_row(make_req(OP_LEARN, ones, 8'd255, 16'hffff, ones, 4'hf), 0, ST_OK, 4'd0);
        add_row(make_req(OP_LEARN, ones, 8'd128, 16'hff00, ones, 4'd0), 1, ST_KNOWN, 4'd0);
        add_row(make_req(OP_LEARN, top_bit, 8'd1, 16'h0000, '0, 4'd0), 0, ST_OK, 4'd1);
        add_row(make_req(OP_FIND, ones, 8'd0, 16'd0, '0, 4'd0), 0, ST_OK, 4'd0);
        add_row(make_req(OP_INVALIDATE, '0, 8'd0, 16'd0, '0, 4'd0), 1, ST_OK, 4'd0);
        add_row(make_req(OP_FIND, ones, 8'd0, 16'd0, '0, 4'd0), 0, ST_OK, 4'd0);
        add_row(make_req(OP_ACTIVATE, '0, 8'd0, 16'd0, '0, 4'd15), 1, ST_BADARG, 4'd0);
        add_row(make_req(OP_ACTIVATE, '0, 8'd0, 16'd0, '0, 4'd0), 1, ST_OK, 4'd0);
        add_row(make_req(OP_LEARN, top_bit, 8'd1, 16'h0000, ones, 4'd0), 0, ST_OK, 4'd2);
        add_row(make_req(OP_FIND, top_bit | 128'd1, 8'd0, 16'd0, '0, 4'd0), 0, ST_OK, 4'd0);
        add_row(make_req(OP_FIND, 128'd1, 8'd0, 16'd0, '0, 4'd0), 0, ST_OK, 4'd0);
        add_row(make_req(OP_INVALIDATE, '0, 8'd0, 16'd0, '0, 4'd1), 0, ST_OK, 4'd0);
        add_row(make_req(OP_FIND, top_bit, 8'd0, 16'd0, '0, 4'd0), 0, ST_OK, 4'd0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table
        foreach (directed_rows[i])
        begin
            blank = directed_rows[i].rsp;
            send_req(directed_rows[i].req, directed_rows[i].typed, blank);
        end

        // Random ops over four idling phases
        for (int n = 0; n < N_RANDOM; n++)
        begin
            ph = n * 4 / N_RANDOM;
            send_idle_pct  = (ph == 1) ? 62 : (ph == 3) ? 37 : 0;
            recv_stall_pct = (ph == 2) ? 62 : (ph == 3) ? 37 : 0;
            // quiet stretches inside the busy phases
            if ((n % 100) >= 85)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            // at each phase change, hold off until the table has answered everything
            if (n > 0 && (n * 4 / N_RANDOM) != ((n - 1) * 4 / N_RANDOM))
                while (pending_rsp.size() != 0)
                    @(negedge clk);
            send_req(random_req(), 0, blank);
        end

        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d directed and %0d random ops, %0d results, %0d route hits",
                 directed_rows.size(), N_RANDOM, rsp_count, find_hits);
        $display("mismatches: %0d", error_count);
        if (error_count == 0)
            $display("route_table_prefix_match_test passed");
        else
            $display("route_table_prefix_match_test failed");
        $finish;
    end

endmodule
